@@ design/obd_isotp_response_capture_macros.svh @@
// Assertion macros shared by the response capture block.
`ifndef OBD_ISOTP_RESPONSE_CAPTURE_MACROS_SVH
`define OBD_ISOTP_RESPONSE_CAPTURE_MACROS_SVH

`ifndef NO_ASSERTIONS
`define OIRC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define OIRC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define OIRC_ASSERT(label, prop, msg)
`define OIRC_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

@@ design/oirc_pkg.sv @@
// Types and constants of the ISO-TP response capture block.
package oirc_pkg;

  localparam int TABLE_ROWS = 256;
  localparam int ROW_BYTES  = 11;

  localparam int ROW_AW = (TABLE_ROWS > 1) ? $clog2(TABLE_ROWS) : 1;
  localparam int COL_W  = $clog2(ROW_BYTES);

  localparam logic [3:0] PCI_SF = 4'h0;
  localparam logic [3:0] PCI_FF = 4'h1;
  localparam logic [3:0] PCI_CF = 4'h2;

  localparam logic [7:0]  FC_CTS    = 8'h30;
  localparam logic [7:0]  FC_OVFLW  = 8'h32;
  localparam logic [55:0] FC_TAIL   = 56'hCCCCCCCCCC00FF;
  localparam logic [7:0]  ERASED    = 8'hFF;
  localparam logic [3:0]  CF_SEQ_MAX = 4'h1;

  typedef logic [ROW_BYTES-1:0][7:0] row_t;

  typedef struct packed {
    logic              en;
    logic [ROW_AW-1:0] addr;
  } rd_req_t;

  typedef struct packed {
    logic              en;
    logic [ROW_AW-1:0] addr;
    row_t              data;
  } wr_req_t;

endpackage

@@ design/oirc_row_store.sv @@
// Row-wide table memory with per-row valid bits; unwritten rows read as erased.
module oirc_row_store (
  input  logic              clk,
  input  logic              rst,
  input  oirc_pkg::rd_req_t rd,
  input  oirc_pkg::wr_req_t wr,
  output oirc_pkg::row_t    rdata
);

  oirc_pkg::row_t mem [oirc_pkg::TABLE_ROWS];
  oirc_pkg::row_t mem_q;
  logic [oirc_pkg::TABLE_ROWS-1:0] row_valid;
  logic rd_valid;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd.en) begin
      mem_q <= mem[rd.addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      rd_valid  <= 1'b0;
    end else begin
      if (wr.en) begin
        row_valid[wr.addr] <= 1'b1;
      end
      if (rd.en) begin
        rd_valid <= row_valid[rd.addr];
      end
    end
  end

  assign rdata = rd_valid ? mem_q : {oirc_pkg::ROW_BYTES{oirc_pkg::ERASED}};

endmodule

@@ design/obd_isotp_response_capture.sv @@
// Top level of the ISO-TP response capture block.
// Each transfer on start is handled in order: the addressed table row is read from the
// row memory in the accept cycle, then merged, written back and the result registered
// while busy is high; done, registered from busy, then pulses for one cycle and busy
// is low again in that same cycle. No new transfer is accepted while busy is high, but
// one may be accepted in the done cycle. The receiver cannot stall: a result not
// taken in its done cycle is lost. The table powers up erased (every byte 0xFF)
// through per-row valid bits, with no clearing pass.
module obd_isotp_response_capture (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        func,
  input  logic [28:0] can_id,
  input  logic [63:0] frame_data,
  input  logic [7:0]  read_pid,
  input  logic [3:0]  read_first,
  input  logic [2:0]  read_count,
  output logic        done,
  output logic [3:0]  frame_kind,
  output logic        pid_out_of_range,
  output logic        fc_valid,
  output logic [28:0] fc_id,
  output logic        fc_extended,
  output logic [63:0] fc_data,
  output logic [31:0] read_value,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  `include "obd_isotp_response_capture_macros.svh"

  localparam logic REG_ACCEPT_CONSECUTIVE = 1'b0;
  localparam logic REG_EXTENDED_IDS       = 1'b1;

  logic accept_consecutive;
  logic extended_ids;
  logic multi_frame_row_en;
  logic [7:0] multi_frame_row;

  logic        func_q;
  logic [28:0] can_id_q;
  logic [63:0] frame_data_q;
  logic [3:0]  read_first_q;
  logic [2:0]  read_count_q;
  logic [7:0]  row_q;
  logic        in_range_q;

  logic [3:0]  kind_in;
  logic [7:0]  row_in;
  logic        in_range_in;
  logic        accepted;

  logic [3:0]  kind_q;
  logic        sf_q;
  logic        ff_q;
  logic        cf_q;

  oirc_pkg::rd_req_t rd;
  oirc_pkg::wr_req_t wr;
  oirc_pkg::row_t    cur_row;
  oirc_pkg::row_t    new_row;
  logic [31:0]       rval;

  // config port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_EXTENDED_IDS) ? {31'd0, extended_ids}
                                                 : {31'd0, accept_consecutive};

  always_ff @(posedge clk) begin
    if (rst) begin
      accept_consecutive <= 1'b1;
      extended_ids       <= 1'b0;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[2])
        REG_ACCEPT_CONSECUTIVE: accept_consecutive <= pwdata[0];
        REG_EXTENDED_IDS:       extended_ids       <= pwdata[0];
        default:                ;
      endcase
    end
  end

  // row selection at accept
  assign accepted = start && !busy;
  assign kind_in  = frame_data[7:4];

  always_comb begin
    if (func) begin
      row_in = read_pid;
    end else if (kind_in == oirc_pkg::PCI_SF) begin
      row_in = frame_data[23:16];
    end else if (kind_in == oirc_pkg::PCI_FF) begin
      row_in = frame_data[31:24];
    end else begin
      row_in = multi_frame_row;
    end
  end

  assign in_range_in = ({1'b0, row_in} < 9'(oirc_pkg::TABLE_ROWS));

  assign rd.en   = accepted;
  assign rd.addr = row_in[oirc_pkg::ROW_AW-1:0];

  always_ff @(posedge clk) begin
    if (accepted) begin
      func_q       <= func;
      can_id_q     <= can_id;
      frame_data_q <= frame_data;
      read_first_q <= read_first;
      read_count_q <= read_count;
      row_q        <= row_in;
      in_range_q   <= in_range_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      busy <= accepted;
      done <= busy;
    end
  end

  oirc_row_store u_store (
    .clk   (clk),
    .rst   (rst),
    .rd    (rd),
    .wr    (wr),
    .rdata (cur_row)
  );

  // merge and write back
  assign kind_q = frame_data_q[7:4];
  assign sf_q   = !func_q && (kind_q == oirc_pkg::PCI_SF);
  assign ff_q   = !func_q && (kind_q == oirc_pkg::PCI_FF);
  assign cf_q   = !func_q && (kind_q == oirc_pkg::PCI_CF)
                  && (frame_data_q[3:0] <= oirc_pkg::CF_SEQ_MAX);

  always_comb begin
    new_row = cur_row;
    if (sf_q) begin
      for (int i = 0; i < 5; i++) begin
        new_row[i] = frame_data_q[8*(i+3) +: 8];
      end
    end else if (ff_q) begin
      for (int i = 0; i < 4; i++) begin
        new_row[i] = frame_data_q[8*(i+4) +: 8];
      end
    end else if (cf_q) begin
      for (int i = 0; i < 7; i++) begin
        new_row[i+4] = frame_data_q[8*(i+1) +: 8];
      end
    end
  end

  assign wr.en   = busy && in_range_q && (sf_q || ff_q || cf_q);
  assign wr.addr = row_q[oirc_pkg::ROW_AW-1:0];
  assign wr.data = new_row;

  assign multi_frame_row_en = busy && ff_q && in_range_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      multi_frame_row <= 8'd0;
    end else if (multi_frame_row_en) begin
      multi_frame_row <= row_q;
    end
  end

  // table read, first byte most significant
  always_comb begin
    logic [2:0] n;
    logic [4:0] c;
    logic [7:0] b;
    n    = (read_count_q > 3'd4) ? 3'd4 : read_count_q;
    rval = 32'd0;
    for (int i = 0; i < 4; i++) begin
      c = {1'b0, read_first_q} + 5'(i);
      b = 8'd0;
      if (in_range_q && (c < 5'(oirc_pkg::ROW_BYTES))) begin
        b = cur_row[c[oirc_pkg::COL_W-1:0]];
      end
      if (3'(i) < n) begin
        rval = {rval[23:0], b};
      end
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (busy) begin
      frame_kind       <= func_q ? 4'd0 : kind_q;
      pid_out_of_range <= (sf_q || ff_q) && !in_range_q;
      fc_valid         <= ff_q;
      fc_id            <= ff_q ? (can_id_q - 29'd8) : 29'd0;
      fc_extended      <= ff_q && extended_ids;
      fc_data          <= ff_q ? {oirc_pkg::FC_TAIL,
                                  accept_consecutive ? oirc_pkg::FC_CTS : oirc_pkg::FC_OVFLW}
                               : 64'd0;
      read_value       <= func_q ? rval : 32'd0;
    end
  end

  `OIRC_ASSERT(a_done_follows_transfer, start && !busy |=> busy ##1 done, "result strobe missing after transfer")
  `OIRC_ASSERT_ALWAYS(a_done_not_busy, done |-> !busy, "result strobe while busy")
  `OIRC_ASSERT(a_fc_only_first, done && fc_valid |-> frame_kind == oirc_pkg::PCI_FF && !read_value[0], "flow control on a non-first frame")
  `OIRC_ASSERT(a_read_value_clean, done && read_value != 32'd0 |-> !fc_valid && !pid_out_of_range && frame_kind == 4'd0, "read data on a frame result")

endmodule
